// ===== rtl/core/affine_transform_backface_cull_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform / face cull block
// Concurrent checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AFFINE_TRANSFORM_BACKFACE_CULL_DEFINES_SVH
`define AFFINE_TRANSFORM_BACKFACE_CULL_DEFINES_SVH

`ifndef SYNTH
`define ATBC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ATBC_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define ATBC_ASSERT(lbl, clk, rst, prop, msg)
`define ATBC_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/core/atbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbc_pkg
// Shared widths, codes and types for the vertex transform / face cull block.
// ----------------------------------------------------------------------------
package atbc_pkg;

  localparam int IN_W          = 16;  // input vertex coordinate
  localparam int IDX_W         = 8;   // slot index field
  localparam int COORD_W       = 28;  // transformed coordinate, 8 fraction bits
  localparam int COEF_W        = 16;  // Q4.12 coefficient
  localparam int COEF_ROW_W    = 3 * COEF_W;
  localparam int TRANS_FIELD_W = 20;  // Q12.8 translation
  localparam int TRANS_W       = 3 * TRANS_FIELD_W;
  localparam int PROD_W        = 2 * IN_W;
  localparam int ACC_W         = PROD_W + 2;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int CROSS_W       = 2 * DIFF_W;
  localparam int FACING_W      = 2;
  localparam int CFG_ADDR_W    = 2;
  localparam int CFG_DATA_W    = TRANS_W;
  localparam int S_DATA_W      = IDX_W + 3 * IN_W + 3 * IDX_W;
  localparam int M_RAW_W       = 3 * COORD_W + FACING_W;
  localparam int M_DATA_W      = ((M_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W     = M_DATA_W - M_RAW_W;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_X = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_Y = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROW_Z = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_TRANS = 2'd3;

  // identity matrix at reset
  localparam logic [COEF_ROW_W-1:0] ROW_X_RST = 48'h0000_0000_1000;
  localparam logic [COEF_ROW_W-1:0] ROW_Y_RST = 48'h0000_1000_0000;
  localparam logic [COEF_ROW_W-1:0] ROW_Z_RST = 48'h1000_0000_0000;

  localparam logic OP_VERTEX   = 1'b0;
  localparam logic OP_FACE     = 1'b1;
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FACE   = 1'b1;

  localparam logic [FACING_W-1:0] FACING_BACK  = 2'd0;
  localparam logic [FACING_W-1:0] FACING_FRONT = 2'd1;
  localparam logic [FACING_W-1:0] FACING_EDGE  = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } vertex_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } xf_res_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic                  en;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

// ===== rtl/core/atbc_vstore.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbc_vstore
// Transformed vertex store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module atbc_vstore
  import atbc_pkg::*;
#(
  parameter int SLOTS = 256,
  parameter int AW    = 8
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  vertex_t       wr_data,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output vertex_t       rd_a_data,
  output vertex_t       rd_b_data
);

  vertex_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== rtl/core/atbc_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbc_xform
// Matrix registers and affine transform: three row MACs over x, y, z steps.
// ----------------------------------------------------------------------------
module atbc_xform
  import atbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_wr_t               cfg,
  input  logic                  start,
  input  logic signed [IN_W-1:0] vx,
  input  logic signed [IN_W-1:0] vy,
  input  logic signed [IN_W-1:0] vz,
  output unit_stat_t            stat,
  output xf_res_t               res
);

  localparam int Q_W = ACC_W - 4;

  logic [COEF_ROW_W-1:0]     row_c [3];
  logic [TRANS_W-1:0]        trans;
  logic signed [IN_W-1:0]    v     [3];
  logic signed [COEF_W-1:0]  coef  [3];
  logic signed [PROD_W-1:0]  prod  [3];
  logic signed [ACC_W-1:0]   acc   [3];
  logic signed [ACC_W-1:0]   acc_init [3];
  logic [2:0]                step;

  // round half up to 8 fraction bits, then clamp to the coordinate range
  function automatic coord_t round_sat(input logic signed [ACC_W-1:0] s);
    logic signed [Q_W-1:0] q;
    q = Q_W'(s >>> 4);
    if (q[Q_W-1:COORD_W-1] == '0 || q[Q_W-1:COORD_W-1] == '1) begin
      return q[COORD_W-1:0];
    end else if (q[Q_W-1]) begin
      return {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      return {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      row_c[0] <= ROW_X_RST;
      row_c[1] <= ROW_Y_RST;
      row_c[2] <= ROW_Z_RST;
      trans    <= '0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_ROW_X: row_c[0] <= cfg.data[COEF_ROW_W-1:0];
        REG_ROW_Y: row_c[1] <= cfg.data[COEF_ROW_W-1:0];
        REG_ROW_Z: row_c[2] <= cfg.data[COEF_ROW_W-1:0];
        REG_TRANS: trans    <= cfg.data[TRANS_W-1:0];
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r]     = $signed(row_c[r][COEF_W*step[1:0] +: COEF_W]);
      // translation carries 8 fraction bits; products carry 12
      acc_init[r] = ACC_W'($signed({trans[r*TRANS_FIELD_W +: TRANS_FIELD_W], 4'b0000}))
                    + ACC_W'(8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      step      <= '0;
    end else begin
      stat.done <= !start && stat.busy && (step == 3'd4);
      if (start) begin
        v[0]      <= vx;
        v[1]      <= vy;
        v[2]      <= vz;
        acc       <= acc_init;
        step      <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        for (int r = 0; r < 3; r++) begin
          if (step < 3'd3) begin
            prod[r] <= coef[r] * v[step[1:0]];
          end
          if (step != 3'd0 && step < 3'd4) begin
            acc[r] <= acc[r] + ACC_W'(prod[r]);
          end
        end
        if (step == 3'd4) begin
          res.x     <= round_sat(acc[0]);
          res.y     <= round_sat(acc[1]);
          res.z     <= round_sat(acc[2]);
          stat.busy <= 1'b0;
        end else begin
          step <= step + 3'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/atbc_cull.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atbc_cull
// Face classifier: edge differences, cross product z on one shared multiplier.
// ----------------------------------------------------------------------------
module atbc_cull
  import atbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  vertex_t             va,
  input  vertex_t             vb,
  input  vertex_t             vc,
  output unit_stat_t          stat,
  output logic [FACING_W-1:0] facing
);

  logic signed [DIFF_W-1:0]  e1x, e1y, e2x, e2y;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [CROSS_W-1:0] mul_p;
  logic signed [CROSS_W-1:0] p1, p2;
  logic [1:0]                step;

  always_comb begin
    mul_a = (step == 2'd0) ? e1x : e1y;
    mul_b = (step == 2'd0) ? e2y : e2x;
    mul_p = mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat.busy <= 1'b0;
      stat.done <= 1'b0;
      step      <= '0;
    end else begin
      stat.done <= !start && stat.busy && (step == 2'd2);
      if (start) begin
        e1x       <= DIFF_W'(vb.x) - DIFF_W'(va.x);
        e1y       <= DIFF_W'(vb.y) - DIFF_W'(va.y);
        e2x       <= DIFF_W'(vc.x) - DIFF_W'(va.x);
        e2y       <= DIFF_W'(vc.y) - DIFF_W'(va.y);
        step      <= '0;
        stat.busy <= 1'b1;
      end else if (stat.busy) begin
        unique case (step)
          2'd0: begin
            p1   <= mul_p;
            step <= 2'd1;
          end
          2'd1: begin
            p2   <= mul_p;
            step <= 2'd2;
          end
          2'd2: begin
            // sign of p1 - p2 without the subtract
            if (p1 < p2) begin
              facing <= FACING_BACK;
            end else if (p1 > p2) begin
              facing <= FACING_FRONT;
            end else begin
              facing <= FACING_EDGE;
            end
            stat.busy <= 1'b0;
          end
          default: begin
            stat.busy <= 1'b0;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/affine_transform_backface_cull.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_transform_backface_cull
// Affine vertex transform with stored x/y and back-face classification.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid / s_tready  op in tuser, vertex and face fields
//   m_*       out   m_tvalid / m_tready  kind in tuser, out_x/y/z, facing
//   cfg_*     in    cfg_we               cfg_addr, cfg_wdata
//
// One item at a time. Vertex: the three multiply-accumulate steps of the row
// units plus rounding, from transfer to result.
// Face: reads in ST_RD1 and ST_RD2 on the dual-read vertex store, then the
// three steps of the cross-product unit around its shared multiplier.
// The next item is taken the cycle after its result enters the output
// register; a stalled result only holds up the following one.
// Reset: synchronous; loads the identity matrix, store contents stay unknown.
// ----------------------------------------------------------------------------
`include "affine_transform_backface_cull_defines.svh"

module affine_transform_backface_cull
  import atbc_pkg::*;
#(
  parameter int VERTEX_SLOTS = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // vertex_index, vx, vy, vz, face_first, face_second, face_third
  input  logic [S_DATA_W-1:0]   s_tdata,
  // op
  input  logic [0:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // out_x, out_y, out_z, facing, zero pad
  output logic [M_DATA_W-1:0]   m_tdata,
  // kind
  output logic [0:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SLOT_AW = $clog2(VERTEX_SLOTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XF,
    ST_RD1,
    ST_RD2,
    ST_CX,
    ST_CW,
    ST_OUT
  } state_t;

  state_t              state;
  logic                op_r;
  logic [IDX_W-1:0]    idx_r, f1_r, f2_r, f3_r;
  vertex_t             va, vb, vc;
  vertex_t             mem_a, mem_b;
  logic                out_free, accept;
  logic                xf_start, cull_start;
  unit_stat_t          xf_stat, cull_stat;
  xf_res_t             xf_res;
  logic [FACING_W-1:0] cull_facing;
  cfg_wr_t             cfg;
  logic                wr_en;
  logic [SLOT_AW-1:0]  rd_a_addr, rd_b_addr;
  coord_t              ox, oy, oz;
  logic [FACING_W-1:0] facing_o;

  function automatic logic slot_ok(input logic [IDX_W-1:0] i);
    return 32'(i) < VERTEX_SLOTS;
  endfunction

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign xf_start   = accept && (s_tuser[0] == OP_VERTEX);
  assign cull_start = (state == ST_CX);

  assign cfg.en    = cfg_we;
  assign cfg.index = cfg_addr;
  assign cfg.data  = cfg_wdata;

  assign rd_a_addr = (state == ST_RD1) ? SLOT_AW'(f1_r) : SLOT_AW'(f3_r);
  assign rd_b_addr = SLOT_AW'(f2_r);
  assign wr_en     = (state == ST_OUT) && out_free && (op_r == OP_VERTEX) && slot_ok(idx_r);

  // slots beyond the store read as the origin
  assign vc = slot_ok(f3_r) ? mem_a : '0;

  always_comb begin
    if (op_r == OP_VERTEX) begin
      ox       = xf_res.x;
      oy       = xf_res.y;
      oz       = xf_res.z;
      facing_o = FACING_BACK;
    end else begin
      ox       = '0;
      oy       = '0;
      oz       = '0;
      facing_o = cull_facing;
    end
  end

  atbc_xform u_xform (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .start (xf_start),
    .vx    ($signed(s_tdata[IDX_W +: IN_W])),
    .vy    ($signed(s_tdata[IDX_W + IN_W +: IN_W])),
    .vz    ($signed(s_tdata[IDX_W + 2*IN_W +: IN_W])),
    .stat  (xf_stat),
    .res   (xf_res)
  );

  atbc_vstore #(
    .SLOTS (VERTEX_SLOTS),
    .AW    (SLOT_AW)
  ) u_vstore (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (SLOT_AW'(idx_r)),
    .wr_data   ({xf_res.y, xf_res.x}),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (mem_a),
    .rd_b_data (mem_b)
  );

  atbc_cull u_cull (
    .clk    (clk),
    .rst    (rst),
    .start  (cull_start),
    .va     (va),
    .vb     (vb),
    .vc     (vc),
    .stat   (cull_stat),
    .facing (cull_facing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // a new result in the output state takes over the valid flag
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op_r  <= s_tuser[0];
            idx_r <= s_tdata[IDX_W-1:0];
            f1_r  <= s_tdata[IDX_W + 3*IN_W +: IDX_W];
            f2_r  <= s_tdata[2*IDX_W + 3*IN_W +: IDX_W];
            f3_r  <= s_tdata[3*IDX_W + 3*IN_W +: IDX_W];
            state <= (s_tuser[0] == OP_VERTEX) ? ST_XF : ST_RD1;
          end
        end
        ST_XF: begin
          if (xf_stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_RD1: begin
          state <= ST_RD2;
        end
        ST_RD2: begin
          // first and second corners are on the read ports now
          va    <= slot_ok(f1_r) ? mem_a : '0;
          vb    <= slot_ok(f2_r) ? mem_b : '0;
          state <= ST_CX;
        end
        ST_CX: begin
          state <= ST_CW;
        end
        ST_CW: begin
          if (cull_stat.done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            m_tuser[0] <= (op_r == OP_VERTEX) ? KIND_VERTEX : KIND_FACE;
            m_tdata    <= {{OUT_PAD_W{1'b0}}, facing_o, oz, oy, ox};
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ATBC_ASSERT(a_accept_units_idle, clk, rst, accept |-> (!xf_stat.busy && !cull_stat.busy), "item taken while a unit is busy")
  `ATBC_ASSERT(a_face_to_read, clk, rst, (accept && s_tuser[0] == OP_FACE) |=> (state == ST_RD1), "face transfer did not start reads")
  `ATBC_ASSERT(a_xf_done_in_xf, clk, rst, xf_stat.done |-> (state == ST_XF), "transform finished outside its state")
  `ATBC_ASSERT(a_result_from_out, clk, rst, $rose(m_tvalid) |-> $past(state == ST_OUT), "result raised outside output state")

endmodule

// ===== verif/affine_transform_backface_cull_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_transform_backface_cull_tb
// Self-checking bench for the vertex transform / face cull block. Vertex and
// face items are fed through the input stream and each result on the output
// stream is checked field by field against an in-bench prediction of the
// affine transform, the rounding and saturation, and the sign of the face
// normal. Matrix settings change between phases while the block is idle;
// handshake pressure on both streams varies by phase.
// ----------------------------------------------------------------------------
module affine_transform_backface_cull_tb;
  import atbc_pkg::*;

  localparam int     SLOTS          = 256;
  localparam int     ITEMS_PER_HALF = 213;
  localparam int     SETTLE_CYCLES  = 12;
  localparam int     CYCLE_LIMIT    = 500000;
  localparam longint COORD_MAX      = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint COORD_MIN      = -(longint'(1) <<< (COORD_W - 1));

  typedef enum int {
    CFG_EXTREME,
    CFG_FULL,
    CFG_SMALL,
    CFG_ZERO,
    CFG_ONES
  } matrix_mode_e;

  typedef struct packed {
    logic                   op;
    logic [IDX_W-1:0]       slot;
    logic signed [IN_W-1:0] vx;
    logic signed [IN_W-1:0] vy;
    logic signed [IN_W-1:0] vz;
    logic [IDX_W-1:0]       face_a;
    logic [IDX_W-1:0]       face_b;
    logic [IDX_W-1:0]       face_c;
  } geom_item_t;

  typedef struct packed {
    logic                kind;
    coord_t              x;
    coord_t              y;
    coord_t              z;
    logic [FACING_W-1:0] facing;
  } geom_result_t;

  localparam int ITEM_W = $bits(geom_item_t);

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_DATA_W-1:0]   s_tdata   = '0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_DATA_W-1:0]   m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  affine_transform_backface_cull dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the matrix and of the stored x/y
  logic [COEF_ROW_W-1:0] row_x_copy, row_y_copy, row_z_copy;
  logic [TRANS_W-1:0]    trans_copy;
  coord_t                store_x [SLOTS];
  coord_t                store_y [SLOTS];

  geom_item_t       pending_items [$];
  geom_result_t     awaited_results [$];
  geom_item_t       drv_item;
  bit               in_taken;
  bit               slot_loaded [SLOTS];
  logic [IDX_W-1:0] loaded_slots [$];

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int cycle_count    = 0;
  int mismatches     = 0;
  int vertex_seen    = 0;
  int sat_seen       = 0;
  int settings_used  = 1;
  int face_seen [3]  = '{0, 0, 0};

  function automatic coord_t row_transform(input logic [COEF_ROW_W-1:0]    row,
                                           input logic [TRANS_FIELD_W-1:0] shift,
                                           input geom_item_t               it);
    longint v [3];
    longint acc;
    v[0] = longint'(it.vx);
    v[1] = longint'(it.vy);
    v[2] = longint'(it.vz);
    acc  = longint'($signed(shift)) * 16;
    for (int k = 0; k < 3; k++)
      acc += longint'($signed(row[k*COEF_W +: COEF_W])) * v[k];
    acc = (acc + 8) >>> 4;  // round half up to 8 fraction bits
    if (acc > COORD_MAX) acc = COORD_MAX;
    else if (acc < COORD_MIN) acc = COORD_MIN;
    return coord_t'(acc);
  endfunction

  function automatic geom_result_t transform_and_classify(input geom_item_t it);
    geom_result_t r;
    longint       e1x, e1y, e2x, e2y, nz;
    r = '0;
    if (it.op == OP_VERTEX) begin
      r.kind   = KIND_VERTEX;
      r.x      = row_transform(row_x_copy, trans_copy[0 +: TRANS_FIELD_W], it);
      r.y      = row_transform(row_y_copy, trans_copy[TRANS_FIELD_W +: TRANS_FIELD_W], it);
      r.z      = row_transform(row_z_copy, trans_copy[2*TRANS_FIELD_W +: TRANS_FIELD_W], it);
      r.facing = FACING_BACK;
      store_x[it.slot] = r.x;
      store_y[it.slot] = r.y;
    end else begin
      e1x = longint'(store_x[it.face_b]) - longint'(store_x[it.face_a]);
      e1y = longint'(store_y[it.face_b]) - longint'(store_y[it.face_a]);
      e2x = longint'(store_x[it.face_c]) - longint'(store_x[it.face_a]);
      e2y = longint'(store_y[it.face_c]) - longint'(store_y[it.face_a]);
      nz  = e1x * e2y - e1y * e2x;
      r.kind = KIND_FACE;
      if (nz < 0) r.facing = FACING_BACK;
      else if (nz > 0) r.facing = FACING_FRONT;
      else r.facing = FACING_EDGE;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // input acceptance, output checking and the register mirror, all at the rising edge
  always @(posedge clk) begin : monitor
    geom_result_t want, got;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end else begin
      in_taken = 1'b0;
      if (rst) begin
        row_x_copy = ROW_X_RST;
        row_y_copy = ROW_Y_RST;
        row_z_copy = ROW_Z_RST;
        trans_copy = '0;
      end else begin
        if (cfg_we) begin
          case (cfg_addr)
            REG_ROW_X: row_x_copy = cfg_wdata[COEF_ROW_W-1:0];
            REG_ROW_Y: row_y_copy = cfg_wdata[COEF_ROW_W-1:0];
            REG_ROW_Z: row_z_copy = cfg_wdata[COEF_ROW_W-1:0];
            REG_TRANS: trans_copy = cfg_wdata[TRANS_W-1:0];
            default: ;
          endcase
        end
        if (s_tvalid && s_tready) begin
          awaited_results.push_back(transform_and_classify(drv_item));
          in_taken = 1'b1;
        end
        if (m_tvalid && m_tready) begin
          got.kind   = m_tuser[0];
          got.x      = m_tdata[0 +: COORD_W];
          got.y      = m_tdata[COORD_W +: COORD_W];
          got.z      = m_tdata[2*COORD_W +: COORD_W];
          got.facing = m_tdata[3*COORD_W +: FACING_W];
          if (awaited_results.size() == 0) begin
            $error("result transfer with nothing awaited: kind %0d", got.kind);
            mismatches++;
          end else begin
            want = awaited_results.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("out_x", longint'(want.x), longint'(got.x));
            check_field("out_y", longint'(want.y), longint'(got.y));
            check_field("out_z", longint'(want.z), longint'(got.z));
            check_field("facing", want.facing, got.facing);
            if (want.kind == KIND_VERTEX) begin
              vertex_seen++;
              if (longint'(want.x) inside {COORD_MAX, COORD_MIN} ||
                  longint'(want.y) inside {COORD_MAX, COORD_MIN} ||
                  longint'(want.z) inside {COORD_MAX, COORD_MIN})
                sat_seen++;
            end else begin
              face_seen[want.facing]++;
            end
          end
        end
      end
    end
  end

  // sender: holds an item until its transfer, then maybe idles
  always @(negedge clk) begin : driver
    if (!rst && !(s_tvalid && !in_taken)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
        drv_item = pending_items.pop_front();
        s_tdata  <= {drv_item.face_c, drv_item.face_b, drv_item.face_a,
                     drv_item.vz, drv_item.vy, drv_item.vx, drv_item.slot};
        s_tuser  <= drv_item.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : sink
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic void note_loaded(input logic [IDX_W-1:0] slot);
    if (!slot_loaded[slot]) begin
      slot_loaded[slot] = 1'b1;
      loaded_slots.push_back(slot);
    end
  endfunction

  task automatic queue_vertex(input int slot, input int x, input int y, input int z);
    geom_item_t it;
    it      = '0;
    it.op   = OP_VERTEX;
    it.slot = IDX_W'(slot);
    it.vx   = IN_W'(x);
    it.vy   = IN_W'(y);
    it.vz   = IN_W'(z);
    note_loaded(it.slot);
    pending_items.push_back(it);
  endtask

  task automatic queue_face(input int a, input int b, input int c);
    geom_item_t it;
    it        = '0;
    it.op     = OP_FACE;
    it.face_a = IDX_W'(a);
    it.face_b = IDX_W'(b);
    it.face_c = IDX_W'(c);
    pending_items.push_back(it);
  endtask

  // unused fields carry random junk; faces only name slots already loaded
  function automatic geom_item_t random_item();
    geom_item_t it;
    int         n;
    it = ITEM_W'({$urandom, $urandom, $urandom});
    n  = loaded_slots.size();
    if (n == 0 || $urandom_range(99) < 50) begin
      it.op = OP_VERTEX;
      if ($urandom_range(99) < 30) begin
        it.vx = IN_W'(int'($urandom_range(128)) - 64);
        it.vy = IN_W'(int'($urandom_range(128)) - 64);
        it.vz = IN_W'(int'($urandom_range(128)) - 64);
      end
      note_loaded(it.slot);
    end else begin
      it.op     = OP_FACE;
      it.face_a = loaded_slots[$urandom_range(n - 1)];
      it.face_b = loaded_slots[$urandom_range(n - 1)];
      it.face_c = loaded_slots[$urandom_range(n - 1)];
      case ($urandom_range(19))
        0: it.face_b = it.face_a;
        1: it.face_c = it.face_b;
        default: ;
      endcase
    end
    return it;
  endfunction

  // returns once nothing is queued, in flight or awaited, plus a settle margin
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_items.size() > 0 || s_tvalid || awaited_results.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_matrix(input matrix_mode_e mode);
    logic [CFG_DATA_W-1:0] vals [4];
    logic [CFG_ADDR_W-1:0] regs [4];
    regs = '{REG_ROW_X, REG_ROW_Y, REG_ROW_Z, REG_TRANS};
    vals = '{default: '0};
    case (mode)
      CFG_EXTREME: begin
        vals[0] = CFG_DATA_W'({3{16'h7FFF}});
        vals[1] = CFG_DATA_W'({3{16'h8000}});
        // 8/4096: exposes half-way rounding
        vals[2] = CFG_DATA_W'({16'h0000, 16'h0000, 16'h0008});
        vals[3] = {20'h00000, 20'h80000, 20'h7FFFF};
      end
      CFG_FULL: begin
        for (int r = 0; r < 4; r++) vals[r] = CFG_DATA_W'({$urandom, $urandom});
      end
      CFG_SMALL: begin
        for (int r = 0; r < 3; r++)
          for (int k = 0; k < 3; k++)
            vals[r][k*COEF_W +: COEF_W] = COEF_W'(int'($urandom_range(8192)) - 4096);
        for (int k = 0; k < 3; k++)
          vals[3][k*TRANS_FIELD_W +: TRANS_FIELD_W] =
            TRANS_FIELD_W'(int'($urandom_range(2048)) - 1024);
      end
      CFG_ONES: begin
        for (int r = 0; r < 4; r++) vals[r] = '1;
      end
      default: ;
    endcase
    for (int r = 0; r < 4; r++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= regs[r];
      cfg_wdata <= vals[r];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int           src_pct  [4] = '{0, 75, 0, 23};
    int           sink_pct [4] = '{0, 0, 75, 23};
    matrix_mode_e plan     [8] = '{CFG_FULL, CFG_SMALL, CFG_ZERO, CFG_SMALL,
                                   CFG_ONES, CFG_FULL, CFG_SMALL, CFG_FULL};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity matrix from reset: front, back, collinear, degenerate, extreme inputs
    queue_vertex(0, 0, 0, 0);
    queue_vertex(1, 10, 0, 5);
    queue_vertex(2, 0, 10, -5);
    queue_vertex(3, 20, 0, 0);
    queue_vertex(255, 32767, -32768, 32767);
    queue_vertex(254, -32768, 32767, -32768);
    queue_face(0, 1, 2);
    queue_face(0, 2, 1);
    queue_face(0, 1, 3);
    queue_face(255, 255, 255);
    queue_face(255, 254, 0);
    wait_drained();

    // extreme coefficients: saturation both ways, rounding of exact halves
    program_matrix(CFG_EXTREME);
    settings_used++;
    queue_vertex(10, 32767, 32767, 32767);
    queue_vertex(11, -32768, -32768, -32768);
    queue_vertex(12, 1, 0, 0);
    queue_vertex(13, -1, 0, 0);
    queue_vertex(14, 3, 0, 0);
    queue_vertex(15, -3, 0, 0);
    queue_face(10, 11, 12);
    queue_face(12, 10, 11);

    for (int p = 0; p < 4; p++) begin
      for (int h = 0; h < 2; h++) begin
        // sender pauses here until every awaited result has arrived
        wait_drained();
        src_idle_pct   = src_pct[p];
        sink_stall_pct = sink_pct[p];
        program_matrix(plan[2*p + h]);
        settings_used++;
        repeat (ITEMS_PER_HALF) pending_items.push_back(random_item());
      end
    end
    wait_drained();

    $display("covered %0d vertex results (%0d saturated) and %0d face results",
             vertex_seen, sat_seen, face_seen[0] + face_seen[1] + face_seen[2]);
    $display("over %0d matrix settings; faces: %0d back, %0d front, %0d edge on",
             settings_used, face_seen[FACING_BACK], face_seen[FACING_FRONT],
             face_seen[FACING_EDGE]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
